FILE: design/mvm_pkg.sv
package mvm_pkg;

  localparam int MAX_DIM_DEF     = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int FRAC_BITS       = 16;
  localparam int ACC_W           = 64;
  localparam int DIM_CFG_W       = 5;
  localparam int FIELD_IDX_W     = 4;
  localparam int WORD_W          = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET = DIM_CFG_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_ROW_CNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_CNT = 2'd1;

  localparam logic REQ_MATRIX = 1'b0;
  localparam logic REQ_VECTOR = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [FIELD_IDX_W-1:0]    row_index;
    logic [FIELD_IDX_W-1:0]    col_index;
    logic signed [WORD_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_IDX_W-1:0]    out_row;
    logic signed [WORD_W-1:0]  product;
    logic                      last_in_run;
  } out_word_t;

  typedef struct packed {
    logic                   valid;
    logic                   first;
    logic                   last_col;
    logic                   last_row;
    logic [FIELD_IDX_W-1:0] row;
  } mvm_tag_t;

endpackage

FILE: design/matrix_vector_multiply_core.sv
// Channel | Ports                       | Handshake
// input   | start, busy, in_word        | word taken when start && !busy
// result  | out_valid, out_word         | one-cycle strobe, no back-pressure
// config  | cfg_valid, cfg_ready, cfg_* | write when cfg_valid && cfg_ready
//
// A load word (matrix entry or vector element) is written to its store and leaves busy low.
// The vector word at the last configured column starts a run: busy holds
// while it issues and drains, one multiply-accumulate per cycle set by the
// single read port of each store; row results leave one per row, in row order.
// Reset clears counters, pipeline valids and sets both dimensions to 16;
// store contents stay undefined until written. cfg_ready is always high.
module matrix_vector_multiply_core import mvm_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_word_t              in_word,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_DIM);

  logic [DIM_CFG_W-1:0]          row_cnt_r;
  logic [DIM_CFG_W-1:0]          col_cnt_r;
  logic [IDX_W-1:0]              nr_m1;
  logic [IDX_W-1:0]              nc_m1;
  logic                          accept;
  logic                          col_ok;
  logic                          row_ok;
  logic                          wr_en;
  logic                          run_start;
  logic                          iss_active_r;
  logic                          iss_active_nxt;
  logic [IDX_W-1:0]              row_r;
  logic [IDX_W-1:0]              row_nxt;
  logic [IDX_W-1:0]              col_r;
  logic [IDX_W-1:0]              col_nxt;
  mvm_tag_t                      iss_tag;
  mvm_tag_t                      s1_tag;
  logic signed [VALUE_WIDTH-1:0] mat_q;
  logic signed [VALUE_WIDTH-1:0] vec_q;
  logic                          pipe_busy;

  function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_CFG_W-1:0] n);
    if (n == '0) begin
      return '0;
    end else if (32'(n) > MAX_DIM) begin
      return IDX_W'(MAX_DIM - 1);
    end else begin
      return IDX_W'(n - 1'b1);
    end
  endfunction

  assign nr_m1 = last_idx(row_cnt_r);
  assign nc_m1 = last_idx(col_cnt_r);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= DIM_RESET;
      col_cnt_r <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_CNT: row_cnt_r <= cfg_wdata[DIM_CFG_W-1:0];
        REG_COL_CNT: col_cnt_r <= cfg_wdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept    = start && !busy;
  assign col_ok    = 32'(in_word.col_index) < MAX_DIM;
  assign row_ok    = 32'(in_word.row_index) < MAX_DIM;
  assign wr_en     = accept && col_ok && (in_word.req_type == REQ_VECTOR || row_ok);
  assign run_start = accept && col_ok && in_word.req_type == REQ_VECTOR &&
                     32'(in_word.col_index) == 32'(nc_m1);

  // walk rows by columns
  always_comb begin
    iss_active_nxt = iss_active_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    if (run_start) begin
      iss_active_nxt = 1'b1;
      row_nxt        = '0;
      col_nxt        = '0;
    end else if (iss_active_r) begin
      if (col_r == nc_m1) begin
        col_nxt = '0;
        if (row_r == nr_m1) begin
          iss_active_nxt = 1'b0;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_active_r <= 1'b0;
      row_r        <= '0;
      col_r        <= '0;
    end else begin
      iss_active_r <= iss_active_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
    end
  end

  assign iss_tag.valid    = iss_active_r;
  assign iss_tag.first    = col_r == '0;
  assign iss_tag.last_col = col_r == nc_m1;
  assign iss_tag.last_row = row_r == nr_m1;
  assign iss_tag.row      = FIELD_IDX_W'(row_r);

  mvm_store #(
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_vec  (in_word.req_type == REQ_VECTOR),
    .wr_row  (IDX_W'(in_word.row_index)),
    .wr_col  (IDX_W'(in_word.col_index)),
    .wr_data (in_word.value[VALUE_WIDTH-1:0]),
    .rd_row  (row_r),
    .rd_col  (col_r),
    .tag_in  (iss_tag),
    .mat_q   (mat_q),
    .vec_q   (vec_q),
    .tag_q   (s1_tag)
  );

  mvm_mac #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_q     (mat_q),
    .vec_q     (vec_q),
    .tag_in    (s1_tag),
    .pipe_busy (pipe_busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  assign busy = iss_active_r || s1_tag.valid || pipe_busy;

  a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_start |=> busy)
    else $error("run start did not raise busy");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !run_start) |=> !busy)
    else $error("load word made the block busy");

  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last_in_run) |-> busy)
    else $error("busy dropped before the last row");

  a_result_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result outside a run");

endmodule

FILE: design/mvm_store.sv
module mvm_store import mvm_pkg::*; #(
  parameter int MAX_DIM     = MAX_DIM_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int IDX_W      = $clog2(MAX_DIM),
  localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic                          wr_vec,
  input  logic [IDX_W-1:0]              wr_row,
  input  logic [IDX_W-1:0]              wr_col,
  input  logic signed [VALUE_WIDTH-1:0] wr_data,
  input  logic [IDX_W-1:0]              rd_row,
  input  logic [IDX_W-1:0]              rd_col,
  input  mvm_tag_t                      tag_in,
  output logic signed [VALUE_WIDTH-1:0] mat_q,
  output logic signed [VALUE_WIDTH-1:0] vec_q,
  output mvm_tag_t                      tag_q
);

  logic signed [VALUE_WIDTH-1:0] mat_mem [MAX_DIM*MAX_DIM];
  logic signed [VALUE_WIDTH-1:0] vec_mem [MAX_DIM];
  logic [ADDR_W-1:0]             wr_addr;
  logic [ADDR_W-1:0]             rd_addr;
  logic signed [VALUE_WIDTH-1:0] mat_q_r;
  logic signed [VALUE_WIDTH-1:0] vec_q_r;
  mvm_tag_t                      tag_r;

  assign wr_addr = ADDR_W'(32'(wr_row) * MAX_DIM + 32'(wr_col));
  assign rd_addr = ADDR_W'(32'(rd_row) * MAX_DIM + 32'(rd_col));

  always_ff @(posedge clk) begin
    if (wr_en && !wr_vec) begin
      mat_mem[wr_addr] <= wr_data;
    end
    mat_q_r <= mat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_vec) begin
      vec_mem[wr_col] <= wr_data;
    end
    vec_q_r <= vec_mem[rd_col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else begin
      tag_r <= tag_in;
    end
  end

  assign mat_q = mat_q_r;
  assign vec_q = vec_q_r;
  assign tag_q = tag_r;

endmodule

FILE: design/mvm_mac.sv
module mvm_mac import mvm_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] mat_q,
  input  logic signed [VALUE_WIDTH-1:0] vec_q,
  input  mvm_tag_t                      tag_in,
  output logic                          pipe_busy,
  output logic                          out_valid,
  output out_word_t                     out_word
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SAT_HI  = (64'sd1 <<< (VALUE_WIDTH-1)) - 64'sd1;
  localparam logic signed [ACC_W-1:0] SAT_LO  = -SAT_HI - 64'sd1;

  logic signed [2*VALUE_WIDTH-1:0] prod_r;
  mvm_tag_t                        s2_tag_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic signed [ACC_W-1:0]         acc_nxt;
  mvm_tag_t                        s3_tag_r;
  logic signed [ACC_W-1:0]         acc_base;
  logic signed [ACC_W-1:0]         addend;
  logic signed [ACC_W-1:0]         sum;
  logic signed [ACC_W-1:0]         shifted;
  logic signed [ACC_W-1:0]         sat_val;
  logic                            out_valid_r;
  out_word_t                       out_word_r;

  // multiply stage
  always_ff @(posedge clk) begin
    prod_r <= mat_q * vec_q;
  end

  // saturating accumulate
  always_comb begin
    acc_base = s2_tag_r.first ? '0 : acc_r;
    addend   = ACC_W'(prod_r);
    sum      = acc_base + addend;
    acc_nxt  = sum;
    if (acc_base[ACC_W-1] == addend[ACC_W-1] && sum[ACC_W-1] != addend[ACC_W-1]) begin
      acc_nxt = addend[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_tag_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  // scale back and clip
  always_comb begin
    shifted = acc_r >>> FRAC_BITS;
    if (shifted > SAT_HI) begin
      sat_val = SAT_HI;
    end else if (shifted < SAT_LO) begin
      sat_val = SAT_LO;
    end else begin
      sat_val = shifted;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r.out_row     <= s3_tag_r.row;
    out_word_r.product     <= WORD_W'(sat_val[VALUE_WIDTH-1:0]);
    out_word_r.last_in_run <= s3_tag_r.last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_tag_r    <= '0;
      s3_tag_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s2_tag_r    <= tag_in;
      s3_tag_r    <= s2_tag_r;
      out_valid_r <= s3_tag_r.valid && s3_tag_r.last_col;
    end
  end

  assign pipe_busy = s2_tag_r.valid || s3_tag_r.valid;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_row_end_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_tag_r.valid && s3_tag_r.last_col) |=> out_valid)
    else $error("row end lost on the way to the output");

  a_acc_starts_row: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_tag_r.valid && s2_tag_r.first) |=> (acc_r == $past(addend)))
    else $error("first column did not restart the sum");

  a_last_row_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.last_in_run) |-> !pipe_busy)
    else $error("work still in flight after the last row");

endmodule
